@@ rtl/core/mvm_pkg.sv @@
// ----------------------------------------------------------------------------
// mvm_pkg: shared types and constants for the matrix-vector multiply core
// Holds the register indexes, queue sizing and the records that travel
// between the front end and the multiply-accumulate back end.
// ----------------------------------------------------------------------------
package mvm_pkg;

	// Default capacity of the vector store.
	localparam int MAX_COLS_DEF = 1024;

	// Entries of the queue between front and back.
	localparam int Q_DEPTH = 4;
	localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

	// Entries of the result queue.
	localparam int RES_DEPTH = 2;

	localparam int CFG_W = 16;

	typedef enum logic {
		REG_NUM_COLS = 1'b0,
		REG_NUM_ROWS = 1'b1
	} mvm_reg_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_MATRIX = 1'b1
	} mvm_opcode_t;

	// One matrix element paired with its vector element.
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] a;
		logic               row_end;
		logic [15:0]        row;
		logic               last;
	} mvm_op_t;

	typedef struct packed {
		logic signed [63:0] row_sum;
		logic [15:0]        row_index;
		logic               last_row;
	} mvm_res_t;

	// Address bits for a store of the given depth (at least one).
	function automatic int addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

endpackage

@@ rtl/core/matrix_vector_multiply_core.sv @@
// ----------------------------------------------------------------------------
// matrix_vector_multiply_core: streaming y = A * x in Q16.16 / Q32.32
// Load beats fill the vector store; matrix beats in row-major order are
// multiplied by it and summed with saturation into one result per row.
// ----------------------------------------------------------------------------
// Takes one beat per clock while full is low, load or matrix alike, and needs
// no clearing pass after reset. A matrix beat reads the vector store in the
// cycle it is taken, enters a four-entry queue once registered, and the back
// end multiplies in one stage and accumulates in the next, where a row's
// final beat puts its result into the result queue. The one-per-cycle rate
// is set by the 32x32 multiplier and the 64-bit saturating add, each with a
// register stage of its own. full rises only when the queue, counting the
// beat still waiting on its store read, has no free entry, which happens only
// after pop has been held low and the two-entry result queue has filled.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_core #(
	parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       opcode,
	input  logic [9:0]                 vector_index,
	input  logic signed [31:0]         value,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [63:0]         row_sum,
	output logic [15:0]                row_index,
	output logic                       last_row,
	input  logic                       cfg_write,
	input  logic                       cfg_index,
	input  logic [mvm_pkg::CFG_W-1:0]  cfg_wdata
);

	logic                         mid_push;
	logic                         mid_full;
	logic                         mid_pop;
	logic                         mid_empty;
	logic [mvm_pkg::Q_LVL_W-1:0]  mid_level;
	mvm_pkg::mvm_op_t             mid_in;
	mvm_pkg::mvm_op_t             mid_out;

	mvm_front #(
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.vector_index (vector_index),
		.value        (value),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.q_level      (mid_level),
		.q_push       (mid_push),
		.q_op         (mid_in)
	);

	mvm_fifo #(
		.WIDTH ($bits(mvm_pkg::mvm_op_t)),
		.DEPTH (mvm_pkg::Q_DEPTH)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_in),
		.full   (mid_full),
		.pop    (mid_pop),
		.rdata  (mid_out),
		.empty  (mid_empty),
		.level  (mid_level)
	);

	mvm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_op      (mid_out),
		.q_empty   (mid_empty),
		.q_pop     (mid_pop),
		.empty     (empty),
		.pop       (pop),
		.row_sum   (row_sum),
		.row_index (row_index),
		.last_row  (last_row)
	);

	ap_mid_room: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> !mid_full)
		else $error("work queue overrun: front pushed into a full queue");

	ap_mid_order: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && opcode == mvm_pkg::OP_MATRIX |=> mid_push)
		else $error("matrix beat did not reach the work queue");

	ap_mid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("back end popped an empty work queue");

endmodule

@@ rtl/core/mvm_ram.sv @@
// ----------------------------------------------------------------------------
// mvm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mvm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = mvm_pkg::MAX_COLS_DEF
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [mvm_pkg::addr_w(DEPTH)-1:0]     waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [mvm_pkg::addr_w(DEPTH)-1:0]     raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/mvm_fifo.sv @@
// ----------------------------------------------------------------------------
// mvm_fifo: small register queue
// Flip-flop storage, read from the head pointer, with a fill level.
// ----------------------------------------------------------------------------
module mvm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mvm_pkg::Q_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  logic [WIDTH-1:0]                 wdata,
	output logic                             full,
	input  logic                             pop,
	output logic [WIDTH-1:0]                 rdata,
	output logic                             empty,
	output logic [$clog2(DEPTH+1)-1:0]       level
);

	localparam int PW = mvm_pkg::addr_w(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (level_q == LW'(DEPTH));
	assign empty   = (level_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];
	assign level   = level_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/mvm_front.sv @@
// ----------------------------------------------------------------------------
// mvm_front: input acceptance, vector store and row bookkeeping
// Writes load beats into the vector store, fetches the vector element for
// each matrix beat, tracks column and row counts and hands work to the queue.
// ----------------------------------------------------------------------------
module mvm_front #(
	parameter int MAX_COLS = mvm_pkg::MAX_COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          opcode,
	input  logic [9:0]                    vector_index,
	input  logic signed [31:0]            value,
	input  logic                          cfg_write,
	input  logic                          cfg_index,
	input  logic [mvm_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [mvm_pkg::Q_LVL_W-1:0]   q_level,
	output logic                          q_push,
	output mvm_pkg::mvm_op_t              q_op
);

	localparam int AW = mvm_pkg::addr_w(MAX_COLS);
	localparam int CW = AW + 1;
	localparam int Q_LVL_P1 = mvm_pkg::Q_LVL_W + 1;

	logic [10:0]        num_cols_q;
	logic [15:0]        num_rows_q;
	logic [AW-1:0]      col_cnt_q;
	logic [15:0]        row_cnt_q;

	logic               valid_s1;
	logic signed [31:0] value_s1;
	logic               end_s1;
	logic [15:0]        row_s1;
	logic               last_s1;

	logic               accept;
	logic               take_load;
	logic               take_mat;
	logic [16:0]        cols_eff;
	logic [16:0]        rows_eff;
	logic [CW-1:0]      col_next;
	logic [16:0]        row_next;
	logic               row_end;
	logic               row_last;
	logic [31:0]        x_rd;

	// Reserve a slot for the beat still waiting on the store read.
	assign full = (Q_LVL_P1'(q_level) + Q_LVL_P1'(valid_s1)) >= Q_LVL_P1'(mvm_pkg::Q_DEPTH);

	assign accept    = push && !full;
	assign take_load = accept && (opcode == mvm_pkg::OP_LOAD)
		&& (17'(vector_index) < 17'(MAX_COLS));
	assign take_mat  = accept && (opcode == mvm_pkg::OP_MATRIX);

	always_comb begin
		if (num_cols_q == '0) begin
			cols_eff = 17'd1;
		end else if (17'(num_cols_q) > 17'(MAX_COLS)) begin
			cols_eff = 17'(MAX_COLS);
		end else begin
			cols_eff = 17'(num_cols_q);
		end
		rows_eff = (num_rows_q == '0) ? 17'd1 : 17'(num_rows_q);
		col_next = CW'(col_cnt_q) + 1'b1;
		row_next = 17'(row_cnt_q) + 1'b1;
		row_end  = 17'(col_next) >= cols_eff;
		row_last = row_next >= rows_eff;
	end

	mvm_ram #(
		.WIDTH (32),
		.DEPTH (MAX_COLS)
	) u_vec_ram (
		.clk   (clk),
		.we    (take_load),
		.waddr (AW'(vector_index)),
		.wdata (value),
		.re    (take_mat),
		.raddr (col_cnt_q),
		.rdata (x_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q <= 11'd1;
			num_rows_q <= 16'd1;
			col_cnt_q  <= '0;
			row_cnt_q  <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					mvm_pkg::REG_NUM_COLS: num_cols_q <= cfg_wdata[10:0];
					mvm_pkg::REG_NUM_ROWS: num_rows_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			valid_s1 <= take_mat;
			if (take_mat) begin
				if (row_end) begin
					col_cnt_q <= '0;
					row_cnt_q <= row_last ? '0 : row_next[15:0];
				end else begin
					col_cnt_q <= col_next[AW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_mat) begin
			value_s1 <= value;
			end_s1   <= row_end;
			row_s1   <= row_cnt_q;
			last_s1  <= row_last;
		end
	end

	assign q_push     = valid_s1;
	assign q_op.x     = x_rd;
	assign q_op.a     = value_s1;
	assign q_op.row_end = end_s1;
	assign q_op.row   = row_s1;
	assign q_op.last  = last_s1;

	ap_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		take_mat && row_end && row_last |=> row_cnt_q == '0)
		else $error("row counter did not wrap after the last row");

	ap_col_clear: assert property (@(posedge clk) disable iff (!arst_n)
		take_mat && row_end |=> col_cnt_q == '0)
		else $error("column counter not cleared at row end");

	ap_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		take_load |=> !q_push)
		else $error("load beat produced work for the back end");

endmodule

@@ rtl/core/mvm_back.sv @@
// ----------------------------------------------------------------------------
// mvm_back: multiply-accumulate back end
// Pulls work from the queue, multiplies in one stage, accumulates with
// saturation in the next and queues one result per finished row.
// ----------------------------------------------------------------------------
module mvm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mvm_pkg::mvm_op_t     q_op,
	input  logic                 q_empty,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic signed [63:0]   row_sum,
	output logic [15:0]          row_index,
	output logic                 last_row
);

	localparam int RLW = $clog2(mvm_pkg::RES_DEPTH + 1);

	logic               valid_s2;
	logic signed [63:0] prod_s2;
	logic               end_s2;
	logic [15:0]        row_s2;
	logic               last_s2;

	logic signed [63:0] acc_q;
	logic signed [64:0] sum_wide;
	logic signed [63:0] sum_sat;
	logic               res_full;
	logic               acc_take;
	logic               res_push;
	logic [RLW-1:0]     res_level;
	mvm_pkg::mvm_res_t  res_in;
	mvm_pkg::mvm_res_t  res_out;

	assign acc_take = valid_s2 && (!end_s2 || !res_full);
	assign res_push = acc_take && end_s2;
	assign q_pop    = !q_empty && (!valid_s2 || acc_take);

	always_comb begin
		sum_wide = {acc_q[63], acc_q} + {prod_s2[63], prod_s2};
		if (sum_wide[64] != sum_wide[63]) begin
			sum_sat = sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			sum_sat = sum_wide[63:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			acc_q    <= '0;
		end else begin
			if (q_pop) begin
				valid_s2 <= 1'b1;
			end else if (acc_take) begin
				valid_s2 <= 1'b0;
			end
			if (acc_take) begin
				acc_q <= end_s2 ? '0 : sum_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			prod_s2 <= q_op.x * q_op.a;
			end_s2  <= q_op.row_end;
			row_s2  <= q_op.row;
			last_s2 <= q_op.last;
		end
	end

	assign res_in.row_sum   = sum_sat;
	assign res_in.row_index = row_s2;
	assign res_in.last_row  = last_s2;

	mvm_fifo #(
		.WIDTH ($bits(mvm_pkg::mvm_res_t)),
		.DEPTH (mvm_pkg::RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty),
		.level  (res_level)
	);

	assign row_sum   = res_out.row_sum;
	assign row_index = res_out.row_index;
	assign last_row  = res_out.last_row;

	ap_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |=> acc_q == '0)
		else $error("accumulator not cleared after row result");

	ap_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !acc_take |=> valid_s2 && $stable(prod_s2))
		else $error("stalled product stage lost its beat");

	ap_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> res_level < RLW'(mvm_pkg::RES_DEPTH))
		else $error("row result pushed into a full result queue");

endmodule
